// ----- hw/rtl/lfofl_pkg.sv -----
// Package for the LFO flanger: sizes, config register map, types and the
// quarter-wave sine table built at elaboration.
// No dependencies.
package lfofl_pkg;

  localparam int DELAY_DEPTH  = 1024;
  localparam int SINE_ENTRIES = 1024;

  localparam int ADDR_W    = $clog2(DELAY_DEPTH);
  localparam int PHASE_W   = $clog2(SINE_ENTRIES);
  localparam int QUARTER   = SINE_ENTRIES / 4;
  localparam int QIDX_W    = PHASE_W - 1;
  localparam int PROD_W    = 16 + PHASE_W;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [15:0] sample_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_GAIN,
    REG_AVERAGE_DELAY,
    REG_LFO_AMPLITUDE,
    REG_LFO_WRAP,
    REG_LFO_PHASE_STEP
  } reg_idx_t;

  localparam logic [16:0] DEPTH_GAIN_RST     = 17'd0;
  localparam logic [9:0]  AVERAGE_DELAY_RST  = 10'd250;
  localparam logic [8:0]  LFO_AMPLITUDE_RST  = 9'd240;
  localparam logic [16:0] LFO_WRAP_RST       = 17'd5000;
  localparam logic [25:0] LFO_PHASE_STEP_RST = 26'd13422;

  typedef struct packed {
    logic [16:0] depth_gain;
    logic [9:0]  average_delay;
    logic [8:0]  lfo_amplitude;
    logic [16:0] lfo_wrap;
    logic [25:0] lfo_phase_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_SINE,
    ST_SCALE,
    ST_ADDR,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic phase_en;
    logic sine_en;
    logic scale_en;
    logic addr_en;
    logic mix_en;
    logic load_out;
  } ctl_t;

  // Quarter-wave sine, Q1.15, entry j is round(32767*sin(2*pi*j/SINE_ENTRIES))
  // from a Taylor series in Q2.30.
  typedef logic [15:0] sine_rom_t [0:QUARTER];

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam longint      ONE_Q30  = 64'sd1073741824;
  localparam logic [63:0] SINE_DIV = 64'(2 * SINE_ENTRIES);
  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156};

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int j = 0; j <= QUARTER; j++) begin
      r    = 64'(4 * j);
      x    = (PI_Q30 * r) / SINE_DIV;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int i = 1; i <= 6; i++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[i];
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      v = (sum * 32767 + (ONE_Q30 / 2)) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      rom[j] = 16'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ----- hw/rtl/lfofl_regs.sv -----
// Configuration registers of the LFO flanger, written by index.
// Depends on lfofl_pkg.
module lfofl_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lfofl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfofl_pkg::CFG_W-1:0]      cfg_data,
  output lfofl_pkg::cfg_t                  cfg
);
  import lfofl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_gain     <= DEPTH_GAIN_RST;
      cfg.average_delay  <= AVERAGE_DELAY_RST;
      cfg.lfo_amplitude  <= LFO_AMPLITUDE_RST;
      cfg.lfo_wrap       <= LFO_WRAP_RST;
      cfg.lfo_phase_step <= LFO_PHASE_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEPTH_GAIN:     cfg.depth_gain     <= cfg_data[16:0];
        REG_AVERAGE_DELAY:  cfg.average_delay  <= cfg_data[9:0];
        REG_LFO_AMPLITUDE:  cfg.lfo_amplitude  <= cfg_data[8:0];
        REG_LFO_WRAP:       cfg.lfo_wrap       <= cfg_data[16:0];
        REG_LFO_PHASE_STEP: cfg.lfo_phase_step <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lfofl_delay_mem.sv -----
// Delay line memory: one write port, two read ports, registered read data.
// Depends on lfofl_pkg.
module lfofl_delay_mem (
  input  logic                clk,
  input  logic                wr_en,
  input  lfofl_pkg::addr_t    wr_addr,
  input  lfofl_pkg::sample_t  wr_data,
  input  logic                rd_en,
  input  lfofl_pkg::addr_t    rd_addr_a,
  input  lfofl_pkg::addr_t    rd_addr_b,
  output lfofl_pkg::sample_t  rd_data_a,
  output lfofl_pkg::sample_t  rd_data_b
);
  import lfofl_pkg::*;

  sample_t mem [0:DELAY_DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

  // sequencer never reads and writes in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) !(wr_en && rd_en))
    else $error("delay memory read and write in the same cycle");

endmodule

// ----- hw/rtl/lfofl_ctrl.sv -----
// Sequencer stepping one item through phase, sine, scale, address, mix and
// output steps. Depends on lfofl_pkg.
module lfofl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output lfofl_pkg::ctl_t  ctl
);
  import lfofl_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PHASE;
      ST_PHASE: state_next = ST_SINE;
      ST_SINE:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_MIX;
      ST_MIX:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE);
    ctl          = '0;
    ctl.accept   = (state == ST_IDLE) && in_valid;
    ctl.phase_en = (state == ST_PHASE);
    ctl.sine_en  = (state == ST_SINE);
    ctl.scale_en = (state == ST_SCALE);
    ctl.addr_en  = (state == ST_ADDR);
    ctl.mix_en   = (state == ST_MIX);
    ctl.load_out = (state == ST_OUT) && out_free;
  end

endmodule

// ----- hw/rtl/lfo_flanger.sv -----
// Flanger top level: sine LFO, fractional delay line, interpolation and mix.
// Depends on lfofl_pkg, lfofl_regs, lfofl_delay_mem and lfofl_ctrl.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    audio_in, block_end
//   out      output     out_valid / out_ready  audio_out, block_end_out
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// From acceptance to its result in the output register, an item is walked by
// the sequencer through the phase multiply, sine table, amplitude multiply,
// delay memory read, interpolation and gain multiply, one per state, and the
// sequencer is idle again as the result loads, taking no new item before then.
// The next item is taken while that result waits; a stalled output holds the
// sequencer in its last step. Reset is synchronous; the delay line reads as
// zero until each entry is written, so no clearing pass follows reset.
module lfo_flanger (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               audio_in,
  input  logic                             block_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               audio_out,
  output logic                             block_end_out,
  input  logic                             cfg_wr_en,
  input  logic [lfofl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfofl_pkg::CFG_W-1:0]      cfg_data
);
  import lfofl_pkg::*;

  localparam int DMAX = DELAY_DEPTH - 2;

  cfg_t cfg;
  ctl_t ctl;

  addr_t       wp;
  addr_t       wp_next;
  logic        wrapped;
  logic [16:0] lfo_count;
  logic [16:0] lfo_count_next;
  logic [16:0] count_inc;

  sample_t                 x_hold;
  logic                    be_hold;
  logic [PROD_W-1:0]       prod;
  logic signed [15:0]      sine;
  logic signed [18:0]      offset;
  logic [7:0]              frac;
  logic                    ok_a;
  logic                    ok_b;
  logic signed [24:0]      wet;

  logic [PHASE_W-1:0]      phase;
  logic [1:0]              quad;
  logic [QIDX_W-1:0]       qidx;
  logic signed [15:0]      sine_val;
  logic signed [25:0]      scaled;
  logic signed [19:0]      dq8;
  logic signed [11:0]      d_raw;
  logic [11:0]             d_clamp;
  logic [7:0]              f_clamp;
  addr_t                   rd_addr_a;
  addr_t                   rd_addr_b;
  sample_t                 rd_data_a;
  sample_t                 rd_data_b;
  sample_t                 a_s;
  sample_t                 b_s;
  logic [8:0]              w_a;
  logic signed [25:0]      pa;
  logic signed [25:0]      pb;
  logic signed [25:0]      wet_sum;
  logic signed [42:0]      gp;
  logic signed [42:0]      rounded;
  logic signed [19:0]      y;
  sample_t                 y_sat;

  lfofl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfofl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  lfofl_delay_mem u_mem (
    .clk       (clk),
    .wr_en     (ctl.accept),
    .wr_addr   (wp),
    .wr_data   (audio_in),
    .rd_en     (ctl.addr_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // pointer and LFO counter
  always_comb begin
    wp_next        = (wp == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
    count_inc      = lfo_count + 1'b1;
    lfo_count_next = (count_inc >= cfg.lfo_wrap) ? '0 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      wrapped   <= 1'b0;
      lfo_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        wp        <= wp_next;
        lfo_count <= lfo_count_next;
        if (wp == ADDR_W'(DELAY_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sine lookup with quarter-wave folding
  always_comb begin
    phase    = prod[16 +: PHASE_W];
    quad     = phase[PHASE_W-1 -: 2];
    qidx     = quad[0] ? QIDX_W'(QUARTER) - {1'b0, phase[PHASE_W-3:0]}
                       : {1'b0, phase[PHASE_W-3:0]};
    sine_val = quad[1] ? -$signed(SINE_ROM[qidx]) : $signed(SINE_ROM[qidx]);
    scaled   = $signed({1'b0, cfg.lfo_amplitude}) * sine;
  end

  // delay in Q8, clamped, and read addresses
  always_comb begin
    dq8     = $signed({2'b00, cfg.average_delay, 8'h00}) + 20'(offset);
    d_raw   = dq8[19:8];
    d_clamp = d_raw;
    f_clamp = dq8[7:0];
    if (d_raw < 12'sd1) begin
      d_clamp = 12'd1;
      f_clamp = 8'd0;
    end else if (int'(d_raw) > DMAX) begin
      d_clamp = 12'(DMAX);
      f_clamp = 8'd0;
    end
    rd_addr_a = wp - 1'b1 - ADDR_W'(d_clamp);
    rd_addr_b = rd_addr_a - 1'b1;
  end

  // interpolation and mix
  always_comb begin
    a_s     = ok_a ? rd_data_a : '0;
    b_s     = ok_b ? rd_data_b : '0;
    w_a     = 9'd256 - {1'b0, frac};
    pa      = a_s * $signed({1'b0, w_a});
    pb      = b_s * $signed({2'b00, frac});
    wet_sum = pa + pb;
    gp      = wet * $signed({1'b0, cfg.depth_gain});
    rounded = gp + 43'sd8388608;
    y       = 20'($signed(rounded[42:24])) + 20'(x_hold);
    if (y > 20'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -20'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_hold  <= audio_in;
      be_hold <= block_end;
    end
    if (ctl.phase_en) begin
      prod <= PROD_W'(lfo_count * cfg.lfo_phase_step);
    end
    if (ctl.sine_en) begin
      sine <= sine_val;
    end
    if (ctl.scale_en) begin
      offset <= scaled[25:7];
    end
    if (ctl.addr_en) begin
      frac <= f_clamp;
      ok_a <= wrapped || (rd_addr_a < wp);
      ok_b <= wrapped || (rd_addr_b < wp);
    end
    if (ctl.mix_en) begin
      wet <= wet_sum[24:0];
    end
    if (ctl.load_out) begin
      audio_out     <= y_sat;
      block_end_out <= be_hold;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer took an item while busy");

  a_load_fills_out: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("result load did not set out_valid");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken item");

  a_wp_moves_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(wp))
    else $error("write pointer moved without an item");

endmodule
